// ===== hw/rtl/ladder_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_pkg
// Shared types, constants and the microcode table of the four-pole ladder
// filter: control word layout, operand and destination selects, program steps.
// ----------------------------------------------------------------------------
package ladder_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int STATE_WIDTH_DEF  = 24;

    localparam int COEF_W      = 16;
    localparam int MUL_B_W     = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MODE_W      = 2;
    localparam int PC_W        = 5;

    localparam logic [CFG_DATA_W-1:0] CUTOFF_RESET    = 16'd32768;
    localparam logic [CFG_DATA_W-1:0] RESONANCE_RESET = 16'd0;

    // Q4.14 constants
    localparam logic signed [MUL_B_W-1:0] K_CUT   = 18'sd19005;
    localparam logic signed [MUL_B_W-1:0] K_FB    = 18'sd2458;
    localparam logic signed [MUL_B_W-1:0] K_GAIN  = 18'sd5737;
    localparam logic signed [MUL_B_W-1:0] K_ZERO  = 18'sd4915;
    localparam logic signed [MUL_B_W-1:0] ONE_Q14 = 18'sd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CUTOFF    = 2'd0,
        REG_RESONANCE = 2'd1,
        REG_MODE      = 2'd2
    } reg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_BANDPASS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT
    } seq_op_t;

    typedef enum logic [3:0] {
        A_CUT,
        A_RES,
        A_F,
        A_F2,
        A_F4,
        A_V,
        A_Y0,
        A_Y1,
        A_Y2,
        A_Y3,
        A_P0,
        A_P1,
        A_P2,
        A_P3
    } a_sel_t;

    typedef enum logic [3:0] {
        B_KCUT,
        B_F,
        B_F2,
        B_KFB,
        B_KGAIN,
        B_KZERO,
        B_ONE_MINUS_T,
        B_FB,
        B_G,
        B_OMF
    } b_sel_t;

    typedef enum logic [1:0] {
        SH_13,
        SH_14,
        SH_16
    } shift_t;

    typedef enum logic [2:0] {
        ADD_ZERO,
        ADD_XS,
        ADD_V,
        ADD_Y0,
        ADD_Y1,
        ADD_Y2
    } add_sel_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_F,
        D_F2,
        D_F4,
        D_T,
        D_G,
        D_FB,
        D_V,
        D_STAGE0,
        D_STAGE1,
        D_STAGE2,
        D_STAGE3
    } dest_t;

    typedef enum logic [PC_W-1:0] {
        ST_IDLE,
        ST_FB_MAC,
        ST_FB_WB,
        ST_GAIN_MAC,
        ST_GAIN_WB,
        ST_S0_MAC,
        ST_S0_WB,
        ST_S1_MAC,
        ST_S1_WB,
        ST_S2_MAC,
        ST_S2_WB,
        ST_S3_MAC,
        ST_S3_WB,
        ST_OUT,
        ST_CUT_MAC,
        ST_F_WB,
        ST_F2_MAC,
        ST_F2_WB,
        ST_F4_MAC,
        ST_F4_WB,
        ST_T_WB,
        ST_G_WB,
        ST_FBK_WB
    } step_t;

    typedef struct packed {
        seq_op_t  seq;
        step_t    target;
        logic     mac_en;
        logic     mac_clr;
        a_sel_t   a_sel;
        b_sel_t   b_sel;
        dest_t    wb_dest;
        shift_t   wb_shift;
        add_sel_t wb_add;
        logic     wb_neg;
        logic     out_en;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        seq:      SEQ_NEXT,
        target:   ST_IDLE,
        mac_en:   1'b0,
        mac_clr:  1'b0,
        a_sel:    A_CUT,
        b_sel:    B_KCUT,
        wb_dest:  D_NONE,
        wb_shift: SH_14,
        wb_add:   ADD_ZERO,
        wb_neg:   1'b0,
        out_en:   1'b0
    };

    function automatic ctrl_t with_mac(ctrl_t w, a_sel_t a, b_sel_t b, logic clr);
        ctrl_t r;
        r         = w;
        r.mac_en  = 1'b1;
        r.mac_clr = clr;
        r.a_sel   = a;
        r.b_sel   = b;
        return r;
    endfunction

    function automatic ctrl_t with_wb(ctrl_t w, dest_t d, shift_t sh, add_sel_t add,
                                      logic neg);
        ctrl_t r;
        r          = w;
        r.wb_dest  = d;
        r.wb_shift = sh;
        r.wb_add   = add;
        r.wb_neg   = neg;
        return r;
    endfunction

    function automatic ctrl_t with_jump(ctrl_t w, seq_op_t op, step_t target);
        ctrl_t r;
        r        = w;
        r.seq    = op;
        r.target = target;
        return r;
    endfunction

    // microcode table
    function automatic ctrl_t ucode(step_t pc);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (pc)
            ST_IDLE:     w = with_jump(w, SEQ_WAIT_IN, ST_FB_MAC);
            // feedback from the fourth pole
            ST_FB_MAC:   w = with_mac(w, A_Y3, B_FB, 1'b1);
            ST_FB_WB:    w = with_wb(w, D_V, SH_13, ADD_XS, 1'b1);
            // input gain
            ST_GAIN_MAC: w = with_mac(w, A_V, B_G, 1'b1);
            ST_GAIN_WB:
            begin
                w = with_wb(w, D_V, SH_14, ADD_ZERO, 1'b0);
                w = with_mac(w, A_P0, B_KZERO, 1'b1);
            end
            // pole chain
            ST_S0_MAC:   w = with_mac(w, A_Y0, B_OMF, 1'b0);
            ST_S0_WB:
            begin
                w = with_wb(w, D_STAGE0, SH_14, ADD_V, 1'b0);
                w = with_mac(w, A_P1, B_KZERO, 1'b1);
            end
            ST_S1_MAC:   w = with_mac(w, A_Y1, B_OMF, 1'b0);
            ST_S1_WB:
            begin
                w = with_wb(w, D_STAGE1, SH_14, ADD_Y0, 1'b0);
                w = with_mac(w, A_P2, B_KZERO, 1'b1);
            end
            ST_S2_MAC:   w = with_mac(w, A_Y2, B_OMF, 1'b0);
            ST_S2_WB:
            begin
                w = with_wb(w, D_STAGE2, SH_14, ADD_Y1, 1'b0);
                w = with_mac(w, A_P3, B_KZERO, 1'b1);
            end
            ST_S3_MAC:   w = with_mac(w, A_Y3, B_OMF, 1'b0);
            ST_S3_WB:    w = with_wb(w, D_STAGE3, SH_14, ADD_Y2, 1'b0);
            ST_OUT:
            begin
                w        = with_jump(w, SEQ_WAIT_OUT, ST_IDLE);
                w.out_en = 1'b1;
            end
            // coefficient program
            ST_CUT_MAC:  w = with_mac(w, A_CUT, B_KCUT, 1'b1);
            ST_F_WB:     w = with_wb(w, D_F, SH_16, ADD_ZERO, 1'b0);
            ST_F2_MAC:   w = with_mac(w, A_F, B_F, 1'b1);
            ST_F2_WB:    w = with_wb(w, D_F2, SH_14, ADD_ZERO, 1'b0);
            ST_F4_MAC:   w = with_mac(w, A_F2, B_F2, 1'b1);
            ST_F4_WB:
            begin
                w = with_wb(w, D_F4, SH_14, ADD_ZERO, 1'b0);
                w = with_mac(w, A_F2, B_KFB, 1'b1);
            end
            ST_T_WB:
            begin
                w = with_wb(w, D_T, SH_14, ADD_ZERO, 1'b0);
                w = with_mac(w, A_F4, B_KGAIN, 1'b1);
            end
            ST_G_WB:
            begin
                w = with_wb(w, D_G, SH_14, ADD_ZERO, 1'b0);
                w = with_mac(w, A_RES, B_ONE_MINUS_T, 1'b1);
            end
            ST_FBK_WB:
            begin
                w = with_wb(w, D_FB, SH_14, ADD_ZERO, 1'b0);
                w = with_jump(w, SEQ_GOTO, ST_IDLE);
            end
            default:     w = with_jump(w, SEQ_GOTO, ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ladder_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_in_if
// Sample channel into the ladder filter: valid, ready and one audio sample.
// ----------------------------------------------------------------------------
interface ladder_in_if #(
    parameter int SAMPLE_WIDTH = ladder_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ===== hw/rtl/ladder_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_out_if
// Sample channel out of the ladder filter: valid, ready and one filtered sample.
// ----------------------------------------------------------------------------
interface ladder_out_if #(
    parameter int SAMPLE_WIDTH = ladder_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/ladder_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface ladder_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ladder_pkg::CFG_INDEX_W-1:0] index;
    logic [ladder_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/four_pole_ladder_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_pole_ladder_filter
// Resonant four-pole ladder filter with lowpass, highpass and bandpass modes.
// ----------------------------------------------------------------------------
// One sample item in gives one filtered sample item out. A microprogram drives
// a single shared multiply-accumulate unit: each item passes through the
// program steps of feedback, gain and the four poles and then the output
// step, and the next item is accepted only after that. A finished
// result waits in the output register while the next item is accepted and
// processed; the block stalls only when that register is still full at the
// end of the next item. After reset and after every register write the block
// derives the coefficients from cutoff and resonance and accepts no sample
// meanwhile; register writes are always accepted. Write the
// registers only while no item is in flight. Unused mode code three behaves
// as lowpass; the output is rounded and saturated to the sample width.
// ----------------------------------------------------------------------------
module four_pole_ladder_filter #(
    parameter int SAMPLE_WIDTH = ladder_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = ladder_pkg::STATE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ladder_cfg_if.sink   cfg,
    ladder_in_if.sink    audio,
    ladder_out_if.source filtered
);

    ladder_pkg::ctrl_t ctrl;
    logic              cfg_write;
    logic              in_ready;
    logic              in_accept;
    logic              out_free;

    assign cfg.ready   = 1'b1;
    assign cfg_write   = cfg.valid && cfg.ready;
    assign audio.ready = in_ready;
    assign in_accept   = audio.valid && in_ready;

    ladder_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_valid (cfg.valid),
        .in_valid  (audio.valid),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .in_ready  (in_ready)
    );

    ladder_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .in_accept  (in_accept),
        .sample_in  (audio.sample_in),
        .out_ready  (filtered.ready),
        .out_valid  (filtered.valid),
        .sample_out (filtered.sample_out),
        .out_free   (out_free)
    );

endmodule

// ===== hw/rtl/ladder_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_seq
// Microprogram sequencer: step counter, control word lookup and the
// conditional jumps that wait on the sample channels.
// ----------------------------------------------------------------------------
module ladder_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_valid,
    input  logic              in_valid,
    input  logic              out_free,
    output ladder_pkg::ctrl_t ctrl,
    output logic              in_ready
);

    ladder_pkg::step_t pc_reg;
    ladder_pkg::step_t pc_next;

    assign ctrl     = ladder_pkg::ucode(pc_reg);
    assign in_ready = (ctrl.seq == ladder_pkg::SEQ_WAIT_IN) && !cfg_valid;

    always_comb
    begin
        pc_next = pc_reg;
        if (cfg_write)
        begin
            // new register value, recompute coefficients
            pc_next = ladder_pkg::ST_CUT_MAC;
        end
        else
        begin
            unique case (ctrl.seq)
                ladder_pkg::SEQ_NEXT:
                    pc_next = ladder_pkg::step_t'(pc_reg + ladder_pkg::PC_W'(1));
                ladder_pkg::SEQ_GOTO:
                    pc_next = ctrl.target;
                ladder_pkg::SEQ_WAIT_IN:
                    pc_next = (in_valid && in_ready) ? ctrl.target : pc_reg;
                ladder_pkg::SEQ_WAIT_OUT:
                    pc_next = out_free ? ctrl.target : pc_reg;
                default:
                    pc_next = ladder_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ladder_pkg::ST_CUT_MAC;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/ladder_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_dp
// Datapath: configuration and coefficient registers, pole state, one shared
// multiply-accumulate unit, round/add/saturate write-back and the output stage.
// ----------------------------------------------------------------------------
module ladder_dp #(
    parameter int SAMPLE_WIDTH = ladder_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = ladder_pkg::STATE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ladder_pkg::ctrl_t                  ctrl,
    input  logic                               cfg_write,
    input  logic [ladder_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ladder_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_accept,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample_in,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]     sample_out,
    output logic                               out_free
);

    localparam int SW        = STATE_WIDTH;
    localparam int CW        = ladder_pkg::COEF_W;
    localparam int AW        = SW + 1;
    localparam int BW        = ladder_pkg::MUL_B_W;
    localparam int PW        = AW + BW;
    localparam int ACC_W     = PW + 1;
    localparam int SUM_W     = ACC_W + 1;
    localparam int RW        = SW + SAMPLE_WIDTH + 4;
    localparam int FRAC_DIFF = SW - SAMPLE_WIDTH - 4;
    localparam int XS_LSH    = (FRAC_DIFF > 0) ? FRAC_DIFF : 0;
    localparam int XS_RSH    = (FRAC_DIFF < 0) ? -FRAC_DIFF : 0;

    localparam logic signed [RW-1:0]    XS_HALF  = RW'((64'sd1 <<< XS_RSH) >>> 1);
    localparam logic signed [RW-1:0]    OUT_HALF = RW'((64'sd1 <<< XS_LSH) >>> 1);
    localparam logic signed [SUM_W-1:0] ST_MAX   = SUM_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ST_MIN   = SUM_W'(-(64'sd1 <<< (SW - 1)));
    localparam logic signed [RW-1:0]    SMP_MAX  =
        RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0]    SMP_MIN  = RW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic signed [ACC_W-1:0] HALF_13  = ACC_W'(64'sd4096);
    localparam logic signed [ACC_W-1:0] HALF_14  = ACC_W'(64'sd8192);
    localparam logic signed [ACC_W-1:0] HALF_16  = ACC_W'(64'sd32768);

    // configuration
    logic [ladder_pkg::CFG_DATA_W-1:0] cutoff_reg;
    logic [ladder_pkg::CFG_DATA_W-1:0] resonance_reg;
    ladder_pkg::mode_t                 mode_reg;

    // coefficients
    logic [CW-1:0] f_reg;
    logic [CW-1:0] f2_reg;
    logic [CW-1:0] f4_reg;
    logic [CW-1:0] t_reg;
    logic [CW-1:0] g_reg;
    logic [CW-1:0] fb_reg;

    logic signed [SW-1:0]    xs_reg;
    logic signed [SW-1:0]    v_reg;
    logic signed [SW-1:0]    y_reg [4];
    logic signed [SW-1:0]    p_reg [4];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;

    logic signed [AW-1:0]    a_op;
    logic signed [BW-1:0]    b_op;
    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] rnd;
    logic signed [SW-1:0]    addend;
    logic signed [SUM_W-1:0] wb_sum;
    logic signed [SW-1:0]    wb_sat;
    logic [CW-1:0]           wb_coef;
    logic signed [RW-1:0]    xs_full;
    logic signed [RW-1:0]    res_ext;
    logic signed [RW-1:0]    res_al;
    logic signed [SAMPLE_WIDTH-1:0] res_sat;

    // multiplier operands
    always_comb
    begin
        unique case (ctrl.a_sel)
            ladder_pkg::A_CUT: a_op = AW'(cutoff_reg);
            ladder_pkg::A_RES: a_op = AW'(resonance_reg);
            ladder_pkg::A_F:   a_op = AW'(f_reg);
            ladder_pkg::A_F2:  a_op = AW'(f2_reg);
            ladder_pkg::A_F4:  a_op = AW'(f4_reg);
            ladder_pkg::A_V:   a_op = AW'(v_reg);
            ladder_pkg::A_Y0:  a_op = AW'(y_reg[0]);
            ladder_pkg::A_Y1:  a_op = AW'(y_reg[1]);
            ladder_pkg::A_Y2:  a_op = AW'(y_reg[2]);
            ladder_pkg::A_Y3:  a_op = AW'(y_reg[3]);
            ladder_pkg::A_P0:  a_op = AW'(p_reg[0]);
            ladder_pkg::A_P1:  a_op = AW'(p_reg[1]);
            ladder_pkg::A_P2:  a_op = AW'(p_reg[2]);
            ladder_pkg::A_P3:  a_op = AW'(p_reg[3]);
            default:           a_op = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            ladder_pkg::B_KCUT:        b_op = ladder_pkg::K_CUT;
            ladder_pkg::B_F:           b_op = BW'(f_reg);
            ladder_pkg::B_F2:          b_op = BW'(f2_reg);
            ladder_pkg::B_KFB:         b_op = ladder_pkg::K_FB;
            ladder_pkg::B_KGAIN:       b_op = ladder_pkg::K_GAIN;
            ladder_pkg::B_KZERO:       b_op = ladder_pkg::K_ZERO;
            ladder_pkg::B_ONE_MINUS_T: b_op = ladder_pkg::ONE_Q14 - BW'(t_reg);
            ladder_pkg::B_FB:          b_op = BW'(fb_reg);
            ladder_pkg::B_G:           b_op = BW'(g_reg);
            // 1 - f, negative when f is above one
            ladder_pkg::B_OMF:         b_op = ladder_pkg::ONE_Q14 - BW'(f_reg);
            default:                   b_op = '0;
        endcase
    end

    assign prod     = a_op * b_op;
    assign acc_next = ctrl.mac_clr ? ACC_W'(prod) : acc_reg + ACC_W'(prod);

    // write-back: round half up, add to or subtract from the stage input, saturate
    always_comb
    begin
        unique case (ctrl.wb_shift)
            ladder_pkg::SH_13: rnd = (acc_reg + HALF_13) >>> 13;
            ladder_pkg::SH_14: rnd = (acc_reg + HALF_14) >>> 14;
            ladder_pkg::SH_16: rnd = (acc_reg + HALF_16) >>> 16;
            default:           rnd = (acc_reg + HALF_14) >>> 14;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.wb_add)
            ladder_pkg::ADD_ZERO: addend = '0;
            ladder_pkg::ADD_XS:   addend = xs_reg;
            ladder_pkg::ADD_V:    addend = v_reg;
            ladder_pkg::ADD_Y0:   addend = y_reg[0];
            ladder_pkg::ADD_Y1:   addend = y_reg[1];
            ladder_pkg::ADD_Y2:   addend = y_reg[2];
            default:              addend = '0;
        endcase
    end

    assign wb_sum  = ctrl.wb_neg ? SUM_W'(addend) - SUM_W'(rnd)
                                 : SUM_W'(addend) + SUM_W'(rnd);
    assign wb_coef = wb_sum[CW-1:0];

    always_comb
    begin
        priority if (wb_sum > ST_MAX)
        begin
            wb_sat = SW'(ST_MAX);
        end
        else if (wb_sum < ST_MIN)
        begin
            wb_sat = SW'(ST_MIN);
        end
        else
        begin
            wb_sat = SW'(wb_sum);
        end
    end

    // input alignment to the state format
    assign xs_full = ((RW'(sample_in) <<< XS_LSH) + XS_HALF) >>> XS_RSH;

    // output stage
    always_comb
    begin
        unique case (mode_reg)
            ladder_pkg::MODE_HIGHPASS: res_ext = RW'(xs_reg) - RW'(y_reg[3]) - RW'(y_reg[0]);
            ladder_pkg::MODE_BANDPASS: res_ext = RW'(y_reg[3]) - RW'(y_reg[0]);
            default:                   res_ext = RW'(y_reg[3]);
        endcase
    end

    assign res_al = ((res_ext <<< XS_RSH) + OUT_HALF) >>> XS_LSH;

    always_comb
    begin
        priority if (res_al > SMP_MAX)
        begin
            res_sat = SAMPLE_WIDTH'(SMP_MAX);
        end
        else if (res_al < SMP_MIN)
        begin
            res_sat = SAMPLE_WIDTH'(SMP_MIN);
        end
        else
        begin
            res_sat = SAMPLE_WIDTH'(res_al);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (ctrl.out_en && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // control state, configuration and pole state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cutoff_reg    <= ladder_pkg::CUTOFF_RESET;
            resonance_reg <= ladder_pkg::RESONANCE_RESET;
            mode_reg      <= ladder_pkg::MODE_LOWPASS;
            for (int i = 0; i < 4; i++)
            begin
                y_reg[i] <= '0;
                p_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ladder_pkg::REG_CUTOFF:    cutoff_reg    <= cfg_data;
                    ladder_pkg::REG_RESONANCE: resonance_reg <= cfg_data;
                    ladder_pkg::REG_MODE:
                        mode_reg <= ladder_pkg::mode_t'(cfg_data[ladder_pkg::MODE_W-1:0]);
                    default: ;
                endcase
            end
            unique case (ctrl.wb_dest)
                ladder_pkg::D_STAGE0:
                begin
                    y_reg[0] <= wb_sat;
                    p_reg[0] <= addend;
                end
                ladder_pkg::D_STAGE1:
                begin
                    y_reg[1] <= wb_sat;
                    p_reg[1] <= addend;
                end
                ladder_pkg::D_STAGE2:
                begin
                    y_reg[2] <= wb_sat;
                    p_reg[2] <= addend;
                end
                ladder_pkg::D_STAGE3:
                begin
                    y_reg[3] <= wb_sat;
                    p_reg[3] <= addend;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mac_en)
        begin
            acc_reg <= acc_next;
        end
        if (in_accept)
        begin
            xs_reg <= SW'(xs_full);
        end
        if (ctrl.out_en && out_free)
        begin
            out_data_reg <= res_sat;
        end
        unique case (ctrl.wb_dest)
            ladder_pkg::D_F:  f_reg  <= wb_coef;
            ladder_pkg::D_F2: f2_reg <= wb_coef;
            ladder_pkg::D_F4: f4_reg <= wb_coef;
            ladder_pkg::D_T:  t_reg  <= wb_coef;
            ladder_pkg::D_G:  g_reg  <= wb_coef;
            ladder_pkg::D_FB: fb_reg <= wb_coef;
            ladder_pkg::D_V:  v_reg  <= wb_sat;
            default: ;
        endcase
    end

endmodule
